/* hw/rtl/pkb_pkg.sv */
// Package for the pair-key block sorter.
// Holds the record type, the size constants and the controller state type.
// No dependencies.
`default_nettype none

package pkb_pkg;

   // Number of cells in the sorting chain, which is the block capacity
   localparam int MAX_RECORDS = 64;
   localparam int KEY_W       = 64;
   // Count of held records, 0..MAX_RECORDS
   localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
   // Settle countdown, 0..MAX_RECORDS
   localparam int SET_W       = $clog2(MAX_RECORDS + 2);

   // High word in the upper bits so that a plain compare orders records
   typedef struct packed {
      logic [KEY_W-1:0] high;
      logic [KEY_W-1:0] low;
   } record_type;

   // Controls broadcast to every cell
   typedef struct packed {
      logic shift;   // pop: every cell takes its upper neighbor's record
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SETTLE,
      ST_DRAIN
   } state_type;

endpackage

`default_nettype wire

/* hw/rtl/pkb_cell.sv */
// One cell of the insertion sorting chain.
// Keeps the smallest record seen and hands the larger one to the next cell.
// Depends on pkb_pkg.
`default_nettype none

module pkb_cell
   import pkb_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cell_ctrl_type ctrl,
   // record arriving from the lower neighbor
   input  wire logic          in_valid,
   input  wire record_type    in_rec,
   // held record of the upper neighbor, used while popping
   input  wire logic          up_valid,
   input  wire record_type    up_rec,
   output logic               held_valid,
   output record_type         held_rec,
   output logic               pass_valid,
   output record_type         pass_rec
);

   logic       held_valid_ff, held_valid_in;
   record_type held_rec_ff,   held_rec_in;
   logic       pass_valid_ff, pass_valid_in;
   record_type pass_rec_ff,   pass_rec_in;

   // Insert or pop
   always_comb begin
      held_valid_in = held_valid_ff;
      held_rec_in   = held_rec_ff;
      pass_valid_in = 1'b0;
      pass_rec_in   = pass_rec_ff;
      if (ctrl.shift) begin
         held_valid_in = up_valid;
         held_rec_in   = up_rec;
      end else if (in_valid) begin
         if (!held_valid_ff) begin
            held_valid_in = 1'b1;
            held_rec_in   = in_rec;
         end else if (in_rec < held_rec_ff) begin
            held_rec_in   = in_rec;
            pass_valid_in = 1'b1;
            pass_rec_in   = held_rec_ff;
         end else begin
            pass_valid_in = 1'b1;
            pass_rec_in   = in_rec;
         end
      end
   end

   // Valid flags reset, record payload does not
   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         pass_valid_ff <= 1'b0;
      end else begin
         held_valid_ff <= held_valid_in;
         pass_valid_ff <= pass_valid_in;
      end
      held_rec_ff <= held_rec_in;
      pass_rec_ff <= pass_rec_in;
   end

   assign held_valid = held_valid_ff;
   assign held_rec   = held_rec_ff;
   assign pass_valid = pass_valid_ff;
   assign pass_rec   = pass_rec_ff;

endmodule

`default_nettype wire

/* hw/rtl/pair_key_block_sorter.sv */
// Top level of the pair-key block sorter: controller and chain of cells.
// Depends on pkb_pkg and pkb_cell.
//
// Usage:
//   req_* takes records, one item per cycle while req_tready is high.
//   req_tlast marks the last record of a block. A block also closes when
//   MAX_RECORDS records are held; if that record has no tlast, every result
//   of the block carries rsp_tuser (overflow) high.
//   Each record ripples up the chain one cell per cycle; each cell keeps the
//   smaller record and passes the larger on, so the chain ends up sorted.
//   A block of n records is loaded, then the settle countdown lets the last
//   record travel the full chain, then n results come out on rsp_* one per
//   cycle while rsp_tready is high, smallest first, rsp_tlast on the last one.
//   The chain length sets the settle time. req_tready is low from block close
//   until the last result is taken.
//   Reset (synchronous, active high) empties the chain and the counters.
//   When the receiver stalls, the current result holds on rsp_* and the
//   chain does not shift.
`default_nettype none

module pair_key_block_sorter
   import pkb_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [127:0] req_tdata,   // key_high[63:0], key_low[127:64]
   input  wire logic         req_tlast,   // block_end
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [127:0]      rsp_tdata,   // out_high[63:0], out_low[127:64]
   output logic              rsp_tlast,   // final_record
   output logic              rsp_tuser    // overflow
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] held_count_ff, held_count_in;
   logic [CNT_W-1:0] out_left_ff,   out_left_in;
   logic [SET_W-1:0] settle_ff,     settle_in;
   logic             overflow_ff,   overflow_in;
   logic             in_valid_ff,   in_valid_in;
   record_type       in_rec_ff;

   logic          req_acc, rsp_acc, block_close, full;
   cell_ctrl_type ctrl;

   logic       held_valid [MAX_RECORDS];
   record_type held_rec   [MAX_RECORDS];
   logic       pass_valid [MAX_RECORDS];
   record_type pass_rec   [MAX_RECORDS];

   assign req_tready  = (state_ff == ST_LOAD);
   assign req_acc     = req_tvalid && req_tready;
   assign rsp_tvalid  = (state_ff == ST_DRAIN) && held_valid[0];
   assign rsp_acc     = rsp_tvalid && rsp_tready;
   assign full        = (held_count_ff == CNT_W'(MAX_RECORDS - 1));
   assign block_close = req_acc && (req_tlast || full);
   assign ctrl.shift  = rsp_acc;

   // Controller: next state and counters
   always_comb begin
      state_in      = state_ff;
      held_count_in = held_count_ff;
      out_left_in   = out_left_ff;
      settle_in     = settle_ff;
      overflow_in   = overflow_ff;
      in_valid_in   = req_acc;
      unique case (state_ff)
         ST_LOAD: begin
            if (block_close) begin
               state_in      = ST_SETTLE;
               held_count_in = '0;
               out_left_in   = held_count_ff + CNT_W'(1);
               settle_in     = SET_W'(MAX_RECORDS);
               overflow_in   = full && !req_tlast;
            end else if (req_acc) begin
               held_count_in = held_count_ff + CNT_W'(1);
            end
         end
         ST_SETTLE: begin
            if (settle_ff == '0) begin
               state_in = ST_DRAIN;
            end else begin
               settle_in = settle_ff - SET_W'(1);
            end
         end
         ST_DRAIN: begin
            if (rsp_acc) begin
               out_left_in = out_left_ff - CNT_W'(1);
               if (out_left_ff == CNT_W'(1)) begin
                  state_in = ST_LOAD;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         held_count_ff <= '0;
         out_left_ff   <= '0;
         settle_ff     <= '0;
         overflow_ff   <= 1'b0;
         in_valid_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         held_count_ff <= held_count_in;
         out_left_ff   <= out_left_in;
         settle_ff     <= settle_in;
         overflow_ff   <= overflow_in;
         in_valid_ff   <= in_valid_in;
      end
      in_rec_ff.high <= req_tdata[63:0];
      in_rec_ff.low  <= req_tdata[127:64];
   end

   // Chain of cells, cell 0 holds the smallest record
   for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
      logic       c_in_valid, c_up_valid;
      record_type c_in_rec,   c_up_rec;
      if (i == 0) begin : g_first
         assign c_in_valid = in_valid_ff;
         assign c_in_rec   = in_rec_ff;
      end else begin : g_mid
         assign c_in_valid = pass_valid[i-1];
         assign c_in_rec   = pass_rec[i-1];
      end
      if (i == MAX_RECORDS - 1) begin : g_top
         assign c_up_valid = 1'b0;
         assign c_up_rec   = held_rec[i];
      end else begin : g_inner
         assign c_up_valid = held_valid[i+1];
         assign c_up_rec   = held_rec[i+1];
      end
      pkb_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .in_valid   (c_in_valid),
         .in_rec     (c_in_rec),
         .up_valid   (c_up_valid),
         .up_rec     (c_up_rec),
         .held_valid (held_valid[i]),
         .held_rec   (held_rec[i]),
         .pass_valid (pass_valid[i]),
         .pass_rec   (pass_rec[i])
      );
   end

   // Result item comes straight from cell 0
   assign rsp_tdata = {held_rec[0].low, held_rec[0].high};
   assign rsp_tlast = (out_left_ff == CNT_W'(1));
   assign rsp_tuser = overflow_ff;

endmodule

`default_nettype wire
